// ----- hdl/lru_recency_cache_assert.svh -----
// Assertion macros used by the lru_recency_cache checker.
`ifndef LRU_RECENCY_CACHE_ASSERT_SVH
`define LRU_RECENCY_CACHE_ASSERT_SVH

// Clocked property, switched off while reset is held.
`define LRC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must be low in the cycle after any reset cycle.
`define LRC_ASSERT_RST(lbl, clk, rst_n, sig, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> !sig) else $error(msg);

`endif

// ----- hdl/lrc_pkg.sv -----
// Package for lru_recency_cache: sizes, payload types and cell interface structs.
package lrc_pkg;

  localparam int ENTRIES = 8;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 4;
  localparam int OCC_W   = $clog2(ENTRIES + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic [OCC_W-1:0]         occ_t;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  // Control broadcast to every cell in the cycle a request executes.
  typedef struct packed {
    logic exec;
    logic put;
    logic hit;
  } cell_ctl_t;

  // Search result carried down the chain from the front cell.
  typedef struct packed {
    logic  found;
    data_t value;
  } chain_t;

  // Effective capacity: zero reads as one, large values saturate to the depth.
  function automatic occ_t live_cap(cap_t c);
    occ_t res;
    if (c == '0) begin
      res = occ_t'(1);
    end else if (int'(c) > ENTRIES) begin
      res = occ_t'(ENTRIES);
    end else begin
      res = occ_t'(c);
    end
    return res;
  endfunction

endpackage

// ----- hdl/lru_recency_cache.sv -----
// Top level of lru_recency_cache: request stage, row of recency cells and result register.
//
// Small LRU store of up to ENTRIES key/value pairs held in a row of cells, most recent
// first. A get (in_action = 0) compares the key against every occupied cell at once; the
// first (most recent) match is moved to the front and its value returned with out_hit = 1,
// otherwise out_hit = 0 and out_read_value = 0. A put (in_action = 1) shifts the row back
// by one, writes the pair at the front and drops the oldest pair when the store is full;
// it does not look for an existing copy of the key, so duplicates can be held, and a get
// always finds the newest copy. Every transaction gives exactly one result, 0 on a put.
// Throughput is one transaction per cycle while the result is not stalled. An accepted
// transaction is loaded into the request register; the cells compare and shift while it is
// held there, and the result register is loaded on the same edge as the cells. A
// stalled result holds the request register, which stalls the input. The compare-and-shift
// cycle is set by the match chain that runs from the front cell to the back cell. cfg_wdata
// sets the capacity (0 reads as 1, values above ENTRIES saturate); lowering it below the
// current fill drops the oldest pairs. Write it only while the block is idle. No clearing
// pass is needed after reset: the store starts empty.
module lru_recency_cache (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  lrc_pkg::data_t      in_key,
  input  lrc_pkg::data_t      in_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output lrc_pkg::data_t      out_read_value,
  // capacity register
  input  logic                cfg_we,
  input  lrc_pkg::cap_t       cfg_wdata
);
  import lrc_pkg::*;

  // request stage
  logic    req_valid_r, req_valid_nxt;
  action_t req_action_r, req_action_nxt;
  data_t   req_key_r,   req_key_nxt;
  data_t   req_value_r, req_value_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  logic    out_hit_r,   out_hit_nxt;
  data_t   out_value_r, out_value_nxt;

  // store bookkeeping
  cap_t    cap_r, cap_nxt;
  occ_t    occ_r, occ_nxt;
  occ_t    cap_live;
  occ_t    cap_new;
  occ_t    put_keep;

  logic      exec;
  logic      in_acc;
  cell_ctl_t ctl;
  data_t     head_value;

  chain_t          chain [ENTRIES+1];
  data_t           cell_key   [ENTRIES];
  data_t           cell_value [ENTRIES];
  logic [ENTRIES-1:0] cell_valid;

  // Execute the held request when the result slot is free or being emptied.
  assign exec     = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !exec;
  assign in_acc   = in_valid && !in_stall;

  assign cap_live = live_cap(cap_r);
  assign cap_new  = live_cap(cfg_wdata);
  // On a full store the put keeps cap-1 old pairs; otherwise all of them.
  assign put_keep = (occ_r >= cap_live) ? (cap_live - occ_t'(1)) : occ_r;

  assign ctl.exec = exec;
  assign ctl.put  = (req_action_r == ACT_PUT);
  assign ctl.hit  = (req_action_r == ACT_GET) && chain[ENTRIES].found;

  // Front cell takes the new pair on a put, the promoted pair on a hit.
  assign head_value = ctl.put ? req_value_r : chain[ENTRIES].value;

  assign chain[0].found = 1'b0;
  assign chain[0].value = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign cell_valid[i] = (occ_r > occ_t'(i));
    if (i == 0) begin : g_front
      lrc_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid_i    (cell_valid[i]),
        .cmp_key    (req_key_r),
        .prev_key   (req_key_r),
        .prev_value (head_value),
        .chain_in   (chain[i]),
        .chain_out  (chain[i+1]),
        .key_o      (cell_key[i]),
        .value_o    (cell_value[i])
      );
    end else begin : g_rest
      lrc_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid_i    (cell_valid[i]),
        .cmp_key    (req_key_r),
        .prev_key   (cell_key[i-1]),
        .prev_value (cell_value[i-1]),
        .chain_in   (chain[i]),
        .chain_out  (chain[i+1]),
        .key_o      (cell_key[i]),
        .value_o    (cell_value[i])
      );
    end
  end

  always_comb begin
    req_valid_nxt  = req_valid_r;
    req_action_nxt = req_action_r;
    req_key_nxt    = req_key_r;
    req_value_nxt  = req_value_r;
    if (exec) begin
      req_valid_nxt = 1'b0;
    end
    // Take a new transaction whenever the request register is free this cycle.
    if (in_acc) begin
      req_valid_nxt  = 1'b1;
      req_action_nxt = action_t'(in_action);
      req_key_nxt    = in_key;
      req_value_nxt  = in_value;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_value_nxt = out_value_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (exec) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = ctl.hit;
      out_value_nxt = ctl.hit ? chain[ENTRIES].value : '0;
    end
  end

  always_comb begin
    cap_nxt = cap_r;
    occ_nxt = occ_r;
    if (cfg_we) begin
      // Drop the oldest pairs if the new capacity is below the fill.
      cap_nxt = cfg_wdata;
      if (occ_r > cap_new) begin
        occ_nxt = cap_new;
      end
    end else if (exec && ctl.put) begin
      occ_nxt = put_keep + occ_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= cap_t'(ENTRIES > 15 ? 15 : ENTRIES);
      occ_r       <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cap_r       <= cap_nxt;
      occ_r       <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_action_r <= req_action_nxt;
    req_key_r    <= req_key_nxt;
    req_value_r  <= req_value_nxt;
    out_hit_r    <= out_hit_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

endmodule

// ----- hdl/lrc_cell.sv -----
// One recency slot: holds a key/value pair, compares it, and takes its neighbour's pair on a shift.
module lrc_cell (
  input  logic               clk,
  input  lrc_pkg::cell_ctl_t ctl,
  input  logic               valid_i,
  input  lrc_pkg::data_t     cmp_key,
  input  lrc_pkg::data_t     prev_key,
  input  lrc_pkg::data_t     prev_value,
  input  lrc_pkg::chain_t    chain_in,
  output lrc_pkg::chain_t    chain_out,
  output lrc_pkg::data_t     key_o,
  output lrc_pkg::data_t     value_o
);
  import lrc_pkg::*;

  data_t key_r,   key_nxt;
  data_t value_r, value_nxt;
  logic  match;
  logic  shift;

  assign match = valid_i && (key_r == cmp_key);

  // Pass the first match down; later matches are older duplicates.
  assign chain_out.found = chain_in.found | match;
  assign chain_out.value = chain_in.found ? chain_in.value :
                           (match ? value_r : '0);

  // Shift on every put; on a hit, shift only up to and including the hit slot.
  assign shift = ctl.exec && (ctl.put || (ctl.hit && !chain_in.found));

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (shift) begin
      key_nxt   = prev_key;
      value_nxt = prev_value;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key_o   = key_r;
  assign value_o = value_r;

endmodule

// ----- hdl/lrc_checker.sv -----
// Port-level assertion checker for lru_recency_cache, bound to the top level.
`include "lru_recency_cache_assert.svh"

module lrc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           in_action,
  input lrc_pkg::data_t in_key,
  input lrc_pkg::data_t in_value,
  input logic           out_valid,
  input logic           out_stall,
  input logic           out_hit,
  input lrc_pkg::data_t out_read_value,
  input logic           cfg_we,
  input lrc_pkg::cap_t  cfg_wdata
);
  import lrc_pkg::*;

  `LRC_ASSERT_RST(a_no_result_after_reset, clk, rst_n, out_valid, "result offered after reset")

  `LRC_ASSERT_CLK(a_miss_reads_zero, clk, rst_n, (out_valid && !out_hit) |-> (out_read_value == '0), "miss or put with non-zero value")

  `LRC_ASSERT_CLK(a_result_from_request, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without a request two cycles earlier")

  `LRC_ASSERT_CLK(a_stalled_result_holds, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_hit) && $stable(out_read_value)), "stalled result changed")

endmodule

bind lru_recency_cache lrc_checker u_lrc_checker (.*);
